@@ src/first_fit_lease_allocator_assert.svh @@
// Assertion macros for the first-fit lease allocator.
// Used by the top level; needs nothing else.
`ifndef FIRST_FIT_LEASE_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_LEASE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFLA_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFLA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ffla_pkg.sv @@
// Shared constants, codes and types of the first-fit lease allocator.
// No dependencies; imported by ffla_engine, the top level and the simulation files.
`default_nettype none

package ffla_pkg;

    // Sizes of the managed memory and of the two tables.
    localparam int MEM_WORDS   = 1024;
    localparam int FREE_SLOTS  = 32;
    localparam int LEASE_SLOTS = 32;

    // Derived widths.
    localparam int ADDR_W = $clog2(MEM_WORDS);
    localparam int LEN_W  = $clog2(MEM_WORDS + 1);
    localparam int SUM_W  = LEN_W + 1;
    localparam int FIDX_W = $clog2(FREE_SLOTS);
    localparam int LIDX_W = $clog2(LEASE_SLOTS);
    localparam int FCNT_W = $clog2(FREE_SLOTS + 1);
    localparam int LCNT_W = $clog2(LEASE_SLOTS + 1);
    localparam int CNT_W  = (FCNT_W > LCNT_W) ? FCNT_W : LCNT_W;

    // Fixed field widths of the beats.
    localparam int CMD_W   = 2;
    localparam int SIZE_W  = 11;
    localparam int TIME_W  = 16;
    localparam int STAT_W  = 2;
    localparam int GRANT_W = 10;
    localparam int EVT_W   = 6;
    localparam int CMP_W   = (SIZE_W > LEN_W) ? SIZE_W : LEN_W;

    // Command codes; the last one is unused and only answers done.
    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_MERGE   = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_GRANT = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd3;

    // Table entries.
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  len;
    } free_ent_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] expiry;
    } lease_ent_t;

    // Request handed to the engine.
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SIZE_W-1:0] request_size;
        logic [TIME_W-1:0] lease_expiry;
        logic [TIME_W-1:0] current_time;
    } req_t;

    // Result handed back by the engine.
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [GRANT_W-1:0] grant_start;
        logic [EVT_W-1:0]   event_count;
    } res_t;

    // Fill levels of the two tables.
    typedef struct packed {
        logic [FCNT_W-1:0] free_cnt;
        logic [LCNT_W-1:0] lease_cnt;
    } stat_t;

endpackage

`default_nettype wire

@@ src/ffla_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ffla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ src/ffla_engine.sv @@
// Sequencer of the allocator: owns the free-list and lease-table RAMs and
// walks them for allocate, release and merge. Depends on ffla_pkg, ffla_ram.
`default_nettype none

module ffla_engine (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire ffla_pkg::req_t req,
    output logic                ready,
    output logic                res_valid,
    input  wire logic           res_taken,
    output ffla_pkg::res_t      res,
    output ffla_pkg::stat_t     stat
);

    import ffla_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE    = 19'd1,
        S_A_RD    = 19'd2,
        S_A_CHK   = 19'd4,
        S_D_RD    = 19'd8,
        S_D_WR    = 19'd16,
        S_R_RD    = 19'd32,
        S_R_CHK   = 19'd64,
        S_R_ACT   = 19'd128,
        S_R_MOV   = 19'd256,
        S_M_OUT   = 19'd512,
        S_M_RD    = 19'd1024,
        S_M_CHK   = 19'd2048,
        S_M_SW1   = 19'd4096,
        S_M_SW2   = 19'd8192,
        S_M_SW3   = 19'd16384,
        S_C_FIRST = 19'd32768,
        S_C_RD    = 19'd65536,
        S_C_CHK   = 19'd131072,
        S_DONE    = 19'd262144
    } state_t;

    localparam free_ent_t FREE_RESET = '{start: '0, len: LEN_W'(MEM_WORDS)};

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [TIME_W-1:0] expiry_reg, expiry_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [FCNT_W-1:0] fcnt_reg, fcnt_next;
    logic [LCNT_W-1:0] lcnt_reg, lcnt_next;
    logic              f0_valid_reg, f0_valid_next;
    logic              rd0_reg, rd0_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  best_reg, best_next;
    logic              found_reg, found_next;
    logic [ADDR_W-1:0] best_start_reg, best_start_next;
    logic [LEN_W-1:0]  best_len_reg, best_len_next;
    logic [ADDR_W-1:0] acc_start_reg, acc_start_next;
    logic [LEN_W-1:0]  acc_len_reg, acc_len_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [ADDR_W-1:0] grant_reg, grant_next;

    logic              f_we;
    logic [FIDX_W-1:0] f_waddr;
    free_ent_t         f_wdata;
    logic [FIDX_W-1:0] f_raddr;
    free_ent_t         f_ram_q;
    free_ent_t         f_rd;
    logic              l_we;
    logic [LIDX_W-1:0] l_waddr;
    lease_ent_t        l_wdata;
    logic [LIDX_W-1:0] l_raddr;
    lease_ent_t        l_rd;

    logic [CNT_W-1:0]  ip1;
    logic [CNT_W-1:0]  jp1;
    logic [CNT_W-1:0]  fcnt_w;
    logic [CNT_W-1:0]  lcnt_w;
    logic [LCNT_W-1:0] lcnt_m1;

    // Free list and lease table storage.
    ffla_ram #(.WIDTH($bits(free_ent_t)), .DEPTH(FREE_SLOTS)) u_free_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_ram_q)
    );

    ffla_ram #(.WIDTH($bits(lease_ent_t)), .DEPTH(LEASE_SLOTS)) u_lease_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rd)
    );

    // Entry 0 of the free list reads as the whole memory until first written.
    assign f_rd = (rd0_reg && !f0_valid_reg) ? FREE_RESET : f_ram_q;

    assign ip1     = i_reg + CNT_W'(1);
    assign jp1     = j_reg + CNT_W'(1);
    assign fcnt_w  = CNT_W'(fcnt_reg);
    assign lcnt_w  = CNT_W'(lcnt_reg);
    assign lcnt_m1 = lcnt_reg - LCNT_W'(1);

    assign ready     = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.status      = status_reg;
    assign res.grant_start = GRANT_W'(grant_reg);
    assign res.event_count = EVT_W'(count_reg);
    assign stat.free_cnt   = fcnt_reg;
    assign stat.lease_cnt  = lcnt_reg;

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        size_next       = size_reg;
        expiry_next     = expiry_reg;
        now_next        = now_reg;
        fcnt_next       = fcnt_reg;
        lcnt_next       = lcnt_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        best_next       = best_reg;
        found_next      = found_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        acc_start_next  = acc_start_reg;
        acc_len_next    = acc_len_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        grant_next      = grant_reg;
        f_we            = 1'b0;
        f_waddr         = '0;
        f_wdata         = '0;
        f_raddr         = '0;
        l_we            = 1'b0;
        l_waddr         = '0;
        l_wdata         = '0;
        l_raddr         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    size_next   = req.request_size;
                    expiry_next = req.lease_expiry;
                    now_next    = req.current_time;
                    count_next  = '0;
                    grant_next  = '0;
                    i_next      = '0;
                    found_next  = 1'b0;
                    case (req.command)
                        CMD_ALLOC:
                        begin
                            if (lcnt_reg == LCNT_W'(LEASE_SLOTS))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                            else if (req.request_size == '0)
                            begin
                                status_next = ST_NOFIT;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_A_RD;
                            end
                        end
                        CMD_RELEASE: state_next = S_R_RD;
                        CMD_MERGE:   state_next = S_M_OUT;
                        default:
                        begin
                            status_next = ST_DONE;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end

            // First-fit search over the free list.
            S_A_RD:
            begin
                if (i_reg == fcnt_w)
                begin
                    status_next = ST_NOFIT;
                    state_next  = S_DONE;
                end
                else
                begin
                    f_raddr    = i_reg[FIDX_W-1:0];
                    state_next = S_A_CHK;
                end
            end

            S_A_CHK:
            begin
                if (CMP_W'(size_reg) <= CMP_W'(f_rd.len))
                begin
                    grant_next     = f_rd.start;
                    status_next    = ST_GRANT;
                    l_we           = 1'b1;
                    l_waddr        = lcnt_reg[LIDX_W-1:0];
                    l_wdata.start  = f_rd.start;
                    l_wdata.len    = LEN_W'(size_reg);
                    l_wdata.expiry = expiry_reg;
                    lcnt_next      = lcnt_reg + LCNT_W'(1);
                    if (CMP_W'(size_reg) == CMP_W'(f_rd.len))
                    begin
                        j_next     = i_reg;
                        state_next = S_D_RD;
                    end
                    else
                    begin
                        f_we          = 1'b1;
                        f_waddr       = i_reg[FIDX_W-1:0];
                        f_wdata.start = f_rd.start + ADDR_W'(size_reg);
                        f_wdata.len   = f_rd.len - LEN_W'(size_reg);
                        state_next    = S_DONE;
                    end
                end
                else
                begin
                    i_next     = ip1;
                    state_next = S_A_RD;
                end
            end

            // Close the gap left by a used-up free range.
            S_D_RD:
            begin
                if (jp1 >= fcnt_w)
                begin
                    fcnt_next  = fcnt_reg - FCNT_W'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    f_raddr    = jp1[FIDX_W-1:0];
                    state_next = S_D_WR;
                end
            end

            S_D_WR:
            begin
                f_we       = 1'b1;
                f_waddr    = j_reg[FIDX_W-1:0];
                f_wdata    = f_rd;
                j_next     = jp1;
                state_next = S_D_RD;
            end

            // Release: find the expired lease with the lowest start.
            S_R_RD:
            begin
                if (i_reg == lcnt_w)
                begin
                    state_next = S_R_ACT;
                end
                else
                begin
                    l_raddr    = i_reg[LIDX_W-1:0];
                    state_next = S_R_CHK;
                end
            end

            S_R_CHK:
            begin
                if (l_rd.expiry <= now_reg && (!found_reg || l_rd.start < best_start_reg))
                begin
                    found_next      = 1'b1;
                    best_next       = i_reg;
                    best_start_next = l_rd.start;
                    best_len_next   = l_rd.len;
                end
                i_next     = ip1;
                state_next = S_R_RD;
            end

            S_R_ACT:
            begin
                if (!found_reg)
                begin
                    status_next = ST_DONE;
                    state_next  = S_DONE;
                end
                else if (fcnt_reg == FCNT_W'(FREE_SLOTS))
                begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    f_we          = 1'b1;
                    f_waddr       = fcnt_reg[FIDX_W-1:0];
                    f_wdata.start = best_start_reg;
                    f_wdata.len   = best_len_reg;
                    fcnt_next     = fcnt_reg + FCNT_W'(1);
                    count_next    = count_reg + CNT_W'(1);
                    i_next        = '0;
                    found_next    = 1'b0;
                    if (best_reg == CNT_W'(lcnt_m1))
                    begin
                        lcnt_next  = lcnt_m1;
                        state_next = S_R_RD;
                    end
                    else
                    begin
                        l_raddr    = lcnt_m1[LIDX_W-1:0];
                        state_next = S_R_MOV;
                    end
                end
            end

            // Fill the freed slot with the last lease.
            S_R_MOV:
            begin
                l_we       = 1'b1;
                l_waddr    = best_reg[LIDX_W-1:0];
                l_wdata    = l_rd;
                lcnt_next  = lcnt_m1;
                state_next = S_R_RD;
            end

            // Merge: selection sort of the free list by start.
            S_M_OUT:
            begin
                if (ip1 >= fcnt_w)
                begin
                    if (fcnt_reg <= FCNT_W'(1))
                    begin
                        status_next = ST_DONE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        f_raddr    = '0;
                        i_next     = CNT_W'(1);
                        j_next     = '0;
                        state_next = S_C_FIRST;
                    end
                end
                else
                begin
                    j_next     = i_reg;
                    best_next  = i_reg;
                    state_next = S_M_RD;
                end
            end

            S_M_RD:
            begin
                if (j_reg == fcnt_w)
                begin
                    state_next = S_M_SW1;
                end
                else
                begin
                    f_raddr    = j_reg[FIDX_W-1:0];
                    state_next = S_M_CHK;
                end
            end

            S_M_CHK:
            begin
                if (j_reg == i_reg || f_rd.start < best_start_reg)
                begin
                    best_next       = j_reg;
                    best_start_next = f_rd.start;
                    best_len_next   = f_rd.len;
                end
                j_next     = jp1;
                state_next = S_M_RD;
            end

            S_M_SW1:
            begin
                if (best_reg == i_reg)
                begin
                    i_next     = ip1;
                    state_next = S_M_OUT;
                end
                else
                begin
                    f_raddr    = i_reg[FIDX_W-1:0];
                    state_next = S_M_SW2;
                end
            end

            S_M_SW2:
            begin
                f_we       = 1'b1;
                f_waddr    = best_reg[FIDX_W-1:0];
                f_wdata    = f_rd;
                state_next = S_M_SW3;
            end

            S_M_SW3:
            begin
                f_we          = 1'b1;
                f_waddr       = i_reg[FIDX_W-1:0];
                f_wdata.start = best_start_reg;
                f_wdata.len   = best_len_reg;
                i_next        = ip1;
                state_next    = S_M_OUT;
            end

            // Coalesce the sorted list in place: i reads ahead, j writes.
            S_C_FIRST:
            begin
                acc_start_next = f_rd.start;
                acc_len_next   = f_rd.len;
                state_next     = S_C_RD;
            end

            S_C_RD:
            begin
                if (i_reg == fcnt_w)
                begin
                    f_we          = 1'b1;
                    f_waddr       = j_reg[FIDX_W-1:0];
                    f_wdata.start = acc_start_reg;
                    f_wdata.len   = acc_len_reg;
                    fcnt_next     = FCNT_W'(jp1);
                    status_next   = ST_DONE;
                    state_next    = S_DONE;
                end
                else
                begin
                    f_raddr    = i_reg[FIDX_W-1:0];
                    state_next = S_C_CHK;
                end
            end

            S_C_CHK:
            begin
                if (SUM_W'(acc_start_reg) + SUM_W'(acc_len_reg) == SUM_W'(f_rd.start))
                begin
                    acc_len_next = acc_len_reg + f_rd.len;
                    count_next   = count_reg + CNT_W'(1);
                end
                else
                begin
                    f_we           = 1'b1;
                    f_waddr        = j_reg[FIDX_W-1:0];
                    f_wdata.start  = acc_start_reg;
                    f_wdata.len    = acc_len_reg;
                    j_next         = jp1;
                    acc_start_next = f_rd.start;
                    acc_len_next   = f_rd.len;
                end
                i_next     = ip1;
                state_next = S_C_RD;
            end

            // Hold the result until the output stage takes it.
            S_DONE:
            begin
                if (res_taken)
                begin
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    assign f0_valid_next = f0_valid_reg || (f_we && f_waddr == '0);
    assign rd0_next      = (f_raddr == '0);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fcnt_reg     <= FCNT_W'(1);
            lcnt_reg     <= '0;
            f0_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fcnt_reg     <= fcnt_next;
            lcnt_reg     <= lcnt_next;
            f0_valid_reg <= f0_valid_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        size_reg       <= size_next;
        expiry_reg     <= expiry_next;
        now_reg        <= now_next;
        rd0_reg        <= rd0_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        best_reg       <= best_next;
        found_reg      <= found_next;
        best_start_reg <= best_start_next;
        best_len_reg   <= best_len_next;
        acc_start_reg  <= acc_start_next;
        acc_len_reg    <= acc_len_next;
        count_reg      <= count_next;
        status_reg     <= status_next;
        grant_reg      <= grant_next;
    end

endmodule

`default_nettype wire

@@ src/first_fit_lease_allocator.sv @@
// Allocate reads the free ranges in order, then closes the gap left by a used-up range
// by moving its followers down; release scans the lease table once per lease freed plus a final scan;
// merge sorts the free ranges, then coalesces them; the result then passes the output register.
// The engine takes one request beat at a time; s_tready stays low until its result is in the output register.
// Reset: empty lease table, free list holds the whole memory; no clearing pass.
// Top level of the first-fit lease allocator; depends on ffla_pkg, ffla_engine.
`default_nettype none

module first_fit_lease_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // request_size, lease_expiry, current_time, zero fill
    input  wire logic [1:0]  s_tuser,  // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,  // grant_start, event_count
    output logic [1:0]       m_tuser   // status
);

    import ffla_pkg::*;

`include "first_fit_lease_allocator_assert.svh"

    req_t  req;
    res_t  res;
    stat_t stat;
    logic  eng_ready;
    logic  res_valid;
    logic  res_taken;
    logic  start;
    logic  m_tvalid_reg, m_tvalid_next;
    res_t  out_reg;

    // Unpack the input beat.
    assign req.command      = s_tuser;
    assign req.request_size = s_tdata[SIZE_W-1:0];
    assign req.lease_expiry = s_tdata[SIZE_W +: TIME_W];
    assign req.current_time = s_tdata[SIZE_W+TIME_W +: TIME_W];

    assign s_tready = eng_ready;
    assign start    = s_tvalid && eng_ready;

    ffla_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .ready     (eng_ready),
        .res_valid (res_valid),
        .res_taken (res_taken),
        .res       (res),
        .stat      (stat)
    );

    // Output register: takes a result whenever it is empty or being drained.
    assign res_taken     = res_valid && (!m_tvalid_reg || m_tready);
    assign m_tvalid_next = res_taken || (m_tvalid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_taken)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.event_count, out_reg.grant_start};
    assign m_tuser  = out_reg.status;

    // Checks on the block's own bookkeeping.
    `FFLA_ASSERT_IMPLY(a_fill_bounds, clk, rst_n, 1'b1, stat.free_cnt <= FCNT_W'(FREE_SLOTS) && stat.lease_cnt <= LCNT_W'(LEASE_SLOTS), "table fill count out of range")
    `FFLA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready, "engine took a second beat while busy")
    `FFLA_ASSERT_IMPLY(a_grant_zero, clk, rst_n, m_tvalid && m_tuser != ST_GRANT, m_tdata[GRANT_W-1:0] == '0, "grant start set on a non-grant result")

endmodule

`default_nettype wire

@@ sim/first_fit_lease_allocator_checker.sv @@
// Checker for the first-fit lease allocator: watches both streams, predicts each result.
// Depends on ffla_pkg; instantiated by first_fit_lease_allocator_tb.
`timescale 1ns / 100ps
`default_nettype none

module first_fit_lease_allocator_checker
    import ffla_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    output int               fail_count,
    output int               pending,
    output int               results_seen
);

    // Predicted memory state.
    int unsigned range_start[FREE_SLOTS];
    int unsigned range_len[FREE_SLOTS];
    int unsigned range_cnt;
    int unsigned held_start[LEASE_SLOTS];
    int unsigned held_len[LEASE_SLOTS];
    int unsigned held_exp[LEASE_SLOTS];
    int unsigned held_cnt;

    res_t expected_results[$];

    assign pending = expected_results.size();

    // Removes one free range, closing the gap.
    function automatic void remove_range(int unsigned k);
        for (int unsigned j = k; j + 1 < range_cnt; j++)
        begin
            range_start[j] = range_start[j + 1];
            range_len[j]   = range_len[j + 1];
        end
        range_cnt--;
    endfunction

    // Removes one lease, closing the gap.
    function automatic void remove_lease(int unsigned k);
        for (int unsigned j = k; j + 1 < held_cnt; j++)
        begin
            held_start[j] = held_start[j + 1];
            held_len[j]   = held_len[j + 1];
            held_exp[j]   = held_exp[j + 1];
        end
        held_cnt--;
    endfunction

    // Computes the result of one request beat and updates the state.
    function automatic res_t allocate_result(logic [1:0] cmd, int unsigned size,
                                             int unsigned expiry, int unsigned now);
        res_t r;
        int unsigned i, j, s, l, e, cnt;
        bit found, blocked;
        r = '0;
        cnt = 0;
        r.status = ST_DONE;
        if (cmd == CMD_ALLOC)
        begin
            if (held_cnt >= LEASE_SLOTS)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                found = 0;
                r.status = ST_NOFIT;
                for (i = 0; i < range_cnt && size != 0; i++)
                begin
                    if (size <= range_len[i])
                    begin
                        found = 1;
                        break;
                    end
                end
                if (found)
                begin
                    r.grant_start = GRANT_W'(range_start[i]);
                    held_start[held_cnt] = range_start[i];
                    held_len[held_cnt] = size;
                    held_exp[held_cnt] = expiry;
                    held_cnt++;
                    if (size == range_len[i])
                    begin
                        remove_range(i);
                    end
                    else
                    begin
                        range_start[i] += size;
                        range_len[i]   -= size;
                    end
                    r.status = ST_GRANT;
                end
            end
        end
        else if (cmd == CMD_RELEASE)
        begin
            blocked = 0;
            // Insertion sort of leases by start.
            for (i = 1; i < held_cnt; i++)
            begin
                s = held_start[i]; l = held_len[i]; e = held_exp[i];
                j = i;
                while (j > 0 && held_start[j - 1] > s)
                begin
                    held_start[j] = held_start[j - 1];
                    held_len[j] = held_len[j - 1];
                    held_exp[j] = held_exp[j - 1];
                    j--;
                end
                held_start[j] = s; held_len[j] = l; held_exp[j] = e;
            end
            i = 0;
            while (i < held_cnt)
            begin
                if (held_exp[i] <= now)
                begin
                    if (range_cnt < FREE_SLOTS)
                    begin
                        range_start[range_cnt] = held_start[i];
                        range_len[range_cnt] = held_len[i];
                        range_cnt++;
                        remove_lease(i);
                        cnt++;
                        continue;
                    end
                    blocked = 1;
                end
                i++;
            end
            r.status = blocked ? ST_FULL : ST_DONE;
        end
        else if (cmd == CMD_MERGE)
        begin
            for (i = 1; i < range_cnt; i++)
            begin
                s = range_start[i]; l = range_len[i];
                j = i;
                while (j > 0 && range_start[j - 1] > s)
                begin
                    range_start[j] = range_start[j - 1];
                    range_len[j] = range_len[j - 1];
                    j--;
                end
                range_start[j] = s; range_len[j] = l;
            end
            i = 0;
            while (i + 1 < range_cnt)
            begin
                if (range_start[i] + range_len[i] == range_start[i + 1])
                begin
                    range_len[i] += range_len[i + 1];
                    remove_range(i + 1);
                    cnt++;
                end
                else
                begin
                    i++;
                end
            end
        end
        r.event_count = cnt[EVT_W-1:0];
        return r;
    endfunction

    // Predict on request beats and compare on result beats.
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            range_cnt = 1;
            range_start[0] = 0;
            range_len[0] = MEM_WORDS;
            held_cnt = 0;
            expected_results.delete();
            fail_count = 0;
            results_seen = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat: status %0d grant %0d count %0d",
                                 m_tuser, m_tdata[9:0], m_tdata[15:10]);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.status || m_tdata[9:0] !== want.grant_start
                        || m_tdata[15:10] !== want.event_count)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: expected status %0d grant %0d count %0d,",
                                      " got %0d %0d %0d"},
                                     want.status, want.grant_start, want.event_count,
                                     m_tuser, m_tdata[9:0], m_tdata[15:10]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.insert(expected_results.size(),
                                        allocate_result(s_tuser, s_tdata[10:0],
                                                        s_tdata[26:11], s_tdata[42:27]));
        end
    end

endmodule

`default_nettype wire

@@ sim/first_fit_lease_allocator_tb.sv @@
// Stimulus and verdict for the first-fit lease allocator.
// Depends on ffla_pkg, first_fit_lease_allocator and its checker.
`timescale 1ns / 100ps
`default_nettype none

module first_fit_lease_allocator_tb;
    import ffla_pkg::*;

    localparam int STALL_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    int          fail_count;
    int          pending;
    int          results_seen;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          quiet_cycles = 0;
    int          beats_sent;

    first_fit_lease_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    first_fit_lease_allocator_checker checker_inst (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    // Clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver stalls at random.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on cycles with no beat accepted.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL first_fit_lease_allocator");
            $finish;
        end
    end

    // Sends one request beat, idling first as the current mix asks.
    // Valid stays high after the beat so that beats can follow directly.
    task automatic send_request(logic [1:0] cmd, logic [10:0] size, logic [15:0] expiry,
                                logic [15:0] now);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'd0, now, expiry, size};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_sent++;
    endtask

    // One random beat; mostly allocations of small sizes with a mix of releases and merges.
    task automatic send_random_request();
        int unsigned pick;
        logic [10:0] size;
        pick = $urandom_range(99);
        if ($urandom_range(9) == 0)
            size = 11'($urandom);
        else
            size = 11'($urandom_range(64, 1));
        if (pick < 55)
            send_request(CMD_ALLOC, size, 16'($urandom), 16'($urandom));
        else if (pick < 78)
            send_request(CMD_RELEASE, 11'($urandom), 16'($urandom), 16'($urandom));
        else if (pick < 97)
            send_request(CMD_MERGE, 11'($urandom), 16'($urandom), 16'($urandom));
        else
            send_request(CMD_UNUSED, 11'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        beats_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero, oversized, whole memory, full lease table, full free list.
        send_request(CMD_ALLOC, 11'd0, 16'd0, 16'd0);
        send_request(CMD_ALLOC, 11'd2047, 16'd0, 16'd0);
        send_request(CMD_ALLOC, 11'd1025, 16'd0, 16'd0);
        send_request(CMD_ALLOC, 11'd1024, 16'hFFFF, 16'd0);
        send_request(CMD_ALLOC, 11'd1, 16'd0, 16'd0);
        send_request(CMD_RELEASE, 11'd0, 16'd0, 16'hFFFF);
        send_request(CMD_UNUSED, 11'h7FF, 16'hFFFF, 16'hFFFF);
        for (int k = 0; k < 33; k++)
            send_request(CMD_ALLOC, 11'd31, k[0] ? 16'd10 : 16'd20, 16'd0);
        send_request(CMD_RELEASE, 11'd0, 16'd0, 16'd15);
        send_request(CMD_RELEASE, 11'd0, 16'd0, 16'd25);
        send_request(CMD_MERGE, 11'd0, 16'd0, 16'd0);
        send_request(CMD_MERGE, 11'd0, 16'd0, 16'd0);

        // Hold off until every result has come back.
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        // Random phases with three idle mixes.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 69 : 0;
            recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 25 : 0;
            for (int k = 0; k < 410; k++)
                send_random_request();
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2000) @(posedge clk);

        $display("Covered %0d request beats and %0d result beats across three stall mixes,",
                 beats_sent, results_seen);
        $display("including full lease table, full free list, zero and oversized requests.");
        if (fail_count == 0 && pending == 0)
            $display("PASS first_fit_lease_allocator");
        else
            $display("FAIL first_fit_lease_allocator");
        $finish;
    end

endmodule

`default_nettype wire
